// ----- src/cbpg_pkg.sv -----
// Cubic Bezier point generator: shared types and fixed constants.
// Used by cbpg_div and cubic_bezier_point_generator_top.
package cbpg_pkg;

    localparam int COORD_W   = 16;
    localparam int CNT_W     = 7;
    localparam int IDX_W     = 6;
    localparam int DEN_W     = 18;
    localparam int NUM_W     = 22;
    localparam int MAG_W     = 21;
    localparam int STEP_BITS = 4;
    localparam int RESULT_CAP = 64;

    typedef struct packed {
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
        logic [CNT_W-1:0]          point_count;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] pt_x;
        logic signed [COORD_W-1:0] pt_y;
        logic [IDX_W-1:0]          pt_index;
        logic                      last_point;
    } t_out;

endpackage

// ----- src/cbpg_div.sv -----
// Iterative restoring divider, STEP_BITS quotient bits per cycle.
// Computes round(mag * 2^SHIFT / den) with halves away from zero, then applies the sign.
// Depends on cbpg_pkg.
module cbpg_div import cbpg_pkg::*; #(
    parameter int SHIFT  = 28,
    parameter int DIVD_W = 52
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MAG_W-1:0]    i_mag,
    input  logic                i_neg,
    input  logic [DEN_W-1:0]    i_den,
    output logic                o_done,
    output logic signed [DIVD_W:0] o_quot
);

    localparam int CYC   = DIVD_W / STEP_BITS;
    localparam int CYC_W = $clog2(CYC + 1);

    logic [DIVD_W-1:0] r_dvd;
    logic [DEN_W:0]    r_rem;
    logic [DEN_W-1:0]  r_den;
    logic              r_neg;
    logic [CYC_W-1:0]  r_cnt;
    logic              r_done;
    logic [DIVD_W-1:0] n_dvd;
    logic [DEN_W:0]    n_rem;

    always_comb begin
        logic [DIVD_W-1:0] dvd;
        logic [DEN_W:0]    rem;
        dvd = r_dvd;
        rem = r_rem;
        for (int i = 0; i < STEP_BITS; i++) begin
            rem = {rem[DEN_W-1:0], dvd[DIVD_W-1]};
            dvd = {dvd[DIVD_W-2:0], 1'b0};
            if (rem >= {1'b0, r_den}) begin
                rem    = rem - {1'b0, r_den};
                dvd[0] = 1'b1;
            end
        end
        n_dvd = dvd;
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd <= (DIVD_W'(i_mag) << SHIFT) + DIVD_W'(i_den >> 1);
                r_rem <= '0;
                r_den <= i_den;
                r_neg <= i_neg;
                r_cnt <= CYC_W'(CYC);
            end else if (r_cnt != '0) begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_cnt <= r_cnt - CYC_W'(1);
                r_done <= (r_cnt == CYC_W'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});

endmodule

// ----- src/cubic_bezier_point_generator_top.sv -----
// Cubic Bezier point generator by forward differencing, top level.
// Depends on cbpg_pkg and cbpg_div.
//
// Raise start with a curve while busy is low; busy stays high until the last point has
// been issued. The block squares and cubes the step count, then runs eight scaled
// divisions on one shared divider, and then walks the curve at one point per cycle.
// A count of one skips setup, a count of zero returns at once. Each point appears on
// o_out for one cycle with o_valid high and must be taken then: there is no
// backpressure. The last point carries last_point and is the walked value.
module cubic_bezier_point_generator_top import cbpg_pkg::*; #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_valid,
    output t_out o_out
);

    localparam int SHIFT  = FRAC_BITS - 4;
    localparam int ACC_W  = FRAC_BITS + 24;
    localparam int DIVD_W = ((SHIFT + MAG_W + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int CAP_I  = (MAX_POINTS < RESULT_CAP) ? MAX_POINTS : RESULT_CAP;
    localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAP_I);

    localparam logic [1:0] Q_FD  = 2'd0;
    localparam logic [1:0] Q_SDH = 2'd1;
    localparam logic [1:0] Q_TDH = 2'd2;
    localparam logic [1:0] Q_TS  = 2'd3;
    localparam logic [2:0] JOB_LAST = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DEN2, ST_DEN3, ST_LOAD, ST_WAIT, ST_WALK
    } t_state;

    t_state r_state;
    t_in    r_in;
    logic [IDX_W-1:0]   r_d;
    logic [2*IDX_W-1:0] r_den2;
    logic [DEN_W-1:0]   r_den3;
    logic [2:0]         r_job;
    logic signed [ACC_W-1:0] r_pos [2];
    logic signed [ACC_W-1:0] r_fd  [2];
    logic signed [ACC_W-1:0] r_sdh [2];
    logic signed [ACC_W-1:0] r_tdh [2];
    logic signed [ACC_W-1:0] r_ts  [2];
    logic [IDX_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_left;
    logic               r_valid;
    t_out               r_out;

    logic [CNT_W-1:0]    n_cnt;
    logic signed [NUM_W-1:0] n_num;
    logic [MAG_W-1:0]    n_mag;
    logic                n_neg;
    logic [DEN_W-1:0]    n_den;
    logic                div_start;
    logic                div_done;
    logic signed [DIVD_W:0] div_quot;
    logic signed [ACC_W-1:0] quot_ext;

    function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] w;
        logic signed [ACC_W-1:0] q;
        w = v + (ACC_W'(1) <<< (SHIFT - 1));
        q = w >>> SHIFT;
        if (q > ACC_W'(32767)) begin
            round_sat = 16'sh7FFF;
        end else if (q < -ACC_W'(32768)) begin
            round_sat = 16'sh8000;
        end else begin
            round_sat = q[COORD_W-1:0];
        end
    endfunction

    assign busy = (r_state != ST_IDLE);
    assign n_cnt = (i_in.point_count > CAP_N) ? CAP_N : i_in.point_count;

    always_comb begin
        logic signed [NUM_W-1:0] e0, e1, e2, e3, a, b, t, cub;
        e0 = r_job[0] ? NUM_W'(r_in.p0_y) : NUM_W'(r_in.p0_x);
        e1 = r_job[0] ? NUM_W'(r_in.p1_y) : NUM_W'(r_in.p1_x);
        e2 = r_job[0] ? NUM_W'(r_in.p2_y) : NUM_W'(r_in.p2_x);
        e3 = r_job[0] ? NUM_W'(r_in.p3_y) : NUM_W'(r_in.p3_x);
        a   = e1 - e0;
        b   = e0 - (e1 <<< 1) + e2;
        t   = e1 - e2;
        cub = t + (t <<< 1) + e3 - e0;
        case (r_job[2:1])
            Q_FD: begin
                n_num = a + (a <<< 1);
                n_den = DEN_W'(r_d);
            end
            Q_SDH: begin
                n_num = b + (b <<< 1);
                n_den = DEN_W'(r_den2);
            end
            Q_TDH: begin
                n_num = cub + (cub <<< 1);
                n_den = r_den3;
            end
            default: begin
                n_num = cub;
                n_den = r_den3;
            end
        endcase
        n_neg = n_num[NUM_W-1];
        n_mag = n_neg ? MAG_W'(-n_num) : MAG_W'(n_num);
    end

    assign div_start = (r_state == ST_LOAD);
    assign quot_ext  = ACC_W'(div_quot);

    cbpg_div #(
        .SHIFT  (SHIFT),
        .DIVD_W (DIVD_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (n_mag),
        .i_neg   (n_neg),
        .i_den   (n_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_job   <= '0;
            r_left  <= '0;
            r_k     <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start && n_cnt != '0) begin
                        r_in   <= i_in;
                        r_d    <= IDX_W'(n_cnt - CNT_W'(1));
                        r_left <= n_cnt;
                        r_k    <= '0;
                        r_job  <= '0;
                        r_pos[0] <= ACC_W'(i_in.p0_x) <<< SHIFT;
                        r_pos[1] <= ACC_W'(i_in.p0_y) <<< SHIFT;
                        for (int i = 0; i < 2; i++) begin
                            r_fd[i]  <= '0;
                            r_sdh[i] <= '0;
                            r_tdh[i] <= '0;
                            r_ts[i]  <= '0;
                        end
                        r_state <= (n_cnt == CNT_W'(1)) ? ST_WALK : ST_DEN2;
                    end
                end
                ST_DEN2: begin
                    r_den2  <= (2*IDX_W)'(r_d) * (2*IDX_W)'(r_d);
                    r_state <= ST_DEN3;
                end
                ST_DEN3: begin
                    r_den3  <= DEN_W'(r_den2) * DEN_W'(r_d);
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (div_done) begin
                        case (r_job[2:1])
                            Q_FD:    r_fd[r_job[0]]  <= quot_ext;
                            Q_SDH:   r_sdh[r_job[0]] <= quot_ext;
                            Q_TDH:   r_tdh[r_job[0]] <= quot_ext;
                            Q_TS:    r_ts[r_job[0]]  <= quot_ext;
                            default: ;
                        endcase
                        r_job   <= r_job + 3'd1;
                        r_state <= (r_job == JOB_LAST) ? ST_WALK : ST_LOAD;
                    end
                end
                ST_WALK: begin
                    r_valid          <= 1'b1;
                    r_out.pt_x       <= round_sat(r_pos[0]);
                    r_out.pt_y       <= round_sat(r_pos[1]);
                    r_out.pt_index   <= r_k;
                    r_out.last_point <= (r_left == CNT_W'(1));
                    for (int i = 0; i < 2; i++) begin
                        r_pos[i] <= r_pos[i] + r_fd[i] + r_sdh[i] + r_ts[i];
                        r_fd[i]  <= r_fd[i] + (r_sdh[i] <<< 1) + r_tdh[i];
                        r_sdh[i] <= r_sdh[i] + r_tdh[i];
                    end
                    r_k    <= r_k + IDX_W'(1);
                    r_left <= r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

// ----- bench/cubic_bezier_point_generator_top_test.sv -----
// Self-checking bench for cubic_bezier_point_generator_top: random and corner curves,
// predicted point by point with a forward-differencing model held in a scoreboard class.
// Depends on cbpg_pkg and the generator RTL.
module cubic_bezier_point_generator_top_test
    import cbpg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_POINTS     = 64;
    localparam int FRAC_BITS      = 32;
    localparam int COORD_FRAC     = 4;
    localparam int SCALE_SHIFT    = FRAC_BITS - COORD_FRAC;
    localparam int RANDOM_CURVES  = 310;
    localparam int SETTLE_CYCLES  = 250;
    localparam int WATCHDOG_LIMIT = 3000;

    class curve_walk_board;
        t_out        expected_points[$];
        int unsigned curves_noted;
        int unsigned points_checked;
        int unsigned fail_count;
        int unsigned empty_curves;
        int unsigned single_curves;
        int unsigned capped_curves;
        longint      position_acc[2];
        longint      first_diff[2];
        longint      second_diff_half[2];
        longint      third_diff_half[2];

        function longint scaled_quot(longint x, longint unsigned den);
            bit                neg;
            longint unsigned   mag;
            longint unsigned   q;
            neg = x < 0;
            mag = neg ? -x : x;
            q   = ((mag << SCALE_SHIFT) + den / 2) / den;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function logic signed [COORD_W-1:0] round_coord(longint v);
            longint q;
            q = (v + (longint'(1) << (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return q[COORD_W-1:0];
        endfunction

        function void note_curve(t_in c);
            int unsigned     n;
            longint          ctl[4];
            longint          cub;
            longint          sixth[2];
            longint unsigned d;
            t_out            pt;
            curves_noted++;
            n = c.point_count;
            if (n > MAX_POINTS) n = MAX_POINTS;
            if (n > RESULT_CAP) n = RESULT_CAP;
            if (c.point_count > RESULT_CAP) capped_curves++;
            if (n == 0) begin
                empty_curves++;
                return;
            end
            if (n == 1) single_curves++;
            for (int a = 0; a < 2; a++) begin
                ctl[0] = a ? c.p0_y : c.p0_x;
                ctl[1] = a ? c.p1_y : c.p1_x;
                ctl[2] = a ? c.p2_y : c.p2_x;
                ctl[3] = a ? c.p3_y : c.p3_x;
                position_acc[a] = ctl[0] * (longint'(1) << SCALE_SHIFT);
                sixth[a] = 0;
                if (n >= 2) begin
                    d   = n - 1;
                    cub = 3 * (ctl[1] - ctl[2]) + ctl[3] - ctl[0];
                    first_diff[a]       = scaled_quot(3 * (ctl[1] - ctl[0]), d);
                    second_diff_half[a] = scaled_quot(3 * (ctl[0] - 2 * ctl[1] + ctl[2]),
                                                      d * d);
                    third_diff_half[a]  = scaled_quot(3 * cub, d * d * d);
                    sixth[a]            = scaled_quot(cub, d * d * d);
                end else begin
                    first_diff[a]       = 0;
                    second_diff_half[a] = 0;
                    third_diff_half[a]  = 0;
                end
            end
            for (int k = 0; k < n; k++) begin
                pt.pt_x       = round_coord(position_acc[0]);
                pt.pt_y       = round_coord(position_acc[1]);
                pt.pt_index   = k[IDX_W-1:0];
                pt.last_point = (k + 1 == n);
                expected_points.push_back(pt);
                for (int a = 0; a < 2; a++) begin
                    position_acc[a]     += first_diff[a] + second_diff_half[a] + sixth[a];
                    first_diff[a]       += 2 * second_diff_half[a] + third_diff_half[a];
                    second_diff_half[a] += third_diff_half[a];
                end
            end
        endfunction

        function void check_point(t_out got);
            t_out want;
            if (expected_points.size() == 0) begin
                $error("point transfer with no curve pending: x %0d y %0d index %0d",
                       got.pt_x, got.pt_y, got.pt_index);
                fail_count++;
                return;
            end
            want = expected_points.pop_front();
            points_checked++;
            if (got.pt_x !== want.pt_x) begin
                $error("pt_x: expected %0d, actual %0d", want.pt_x, got.pt_x);
                fail_count++;
            end
            if (got.pt_y !== want.pt_y) begin
                $error("pt_y: expected %0d, actual %0d", want.pt_y, got.pt_y);
                fail_count++;
            end
            if (got.pt_index !== want.pt_index) begin
                $error("pt_index: expected %0d, actual %0d", want.pt_index, got.pt_index);
                fail_count++;
            end
            if (got.last_point !== want.last_point) begin
                $error("last_point: expected %0d, actual %0d", want.last_point,
                       got.last_point);
                fail_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_in;
    logic o_valid;
    t_out o_out;

    curve_walk_board board;
    int unsigned     idle_cycles;
    bit              moved;

    cubic_bezier_point_generator_top #(
        .MAX_POINTS(MAX_POINTS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_in   (i_in),
        .o_valid(o_valid),
        .o_out  (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_in curve_of(int x0, int y0, int x1, int y1, int x2, int y2,
                                     int x3, int y3, int n);
        t_in c;
        c.p0_x = x0[COORD_W-1:0];
        c.p0_y = y0[COORD_W-1:0];
        c.p1_x = x1[COORD_W-1:0];
        c.p1_y = y1[COORD_W-1:0];
        c.p2_x = x2[COORD_W-1:0];
        c.p2_y = y2[COORD_W-1:0];
        c.p3_x = x3[COORD_W-1:0];
        c.p3_y = y3[COORD_W-1:0];
        c.point_count = n[CNT_W-1:0];
        return c;
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0:       return -32768;
            1:       return 32767;
            2:       return $urandom_range(0, 64) - 32;
            default: return $signed($urandom_range(0, 65535) - 32768);
        endcase
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 0;
        if (r < 10) return $urandom_range(65, 127);
        if (r < 16) return 1;
        if (r < 22) return 64;
        return $urandom_range(2, 63);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 95) return $urandom_range(5, 30);
        return $urandom_range(50, 300);
    endfunction

    function automatic t_in random_curve();
        return curve_of(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        pick_count());
    endfunction

    task automatic send_curve(t_in c);
        @(negedge i_clk);
        start <= 1'b1;
        i_in  <= c;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic rest_sender(int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_in  <= random_curve();
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_points();
        rest_sender(1);
        while (board.expected_points.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_valid) begin
                board.check_point(o_out);
                moved = 1'b1;
            end
            if (start && !busy) begin
                board.note_curve(i_in);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", idle_cycles);
                $display("** cubic_bezier_point_generator_top: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        board       = new();
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_curve(curve_of(0, 0, 0, 0, 0, 0, 0, 0, 2));
        send_curve(curve_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 64));
        rest_sender(1);
        send_curve(curve_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, 64));
        send_curve(curve_of(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 2));
        rest_sender(3);
        send_curve(curve_of(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 3));
        send_curve(curve_of(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768,
                            64));
        send_curve(curve_of(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 2));
        send_curve(curve_of(32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768, 7));
        send_curve(curve_of(-32768, 32767, 5, 5, 5, 5, 5, 5, 1));
        send_curve(curve_of(32767, -32768, -5, -5, -5, -5, -5, -5, 1));
        send_curve(curve_of(100, 200, 300, 400, 500, 600, 700, 800, 0));
        send_curve(curve_of(-1, 1, 0, 0, 1, -1, -1, 1, 1));
        rest_sender(2);
        send_curve(curve_of(-1000, 2000, 3000, -4000, 5000, 6000, -7000, 8000, 65));
        send_curve(curve_of(12345, -23456, -31000, 30000, 29000, -28000, 1, -1, 127));
        send_curve(curve_of(0, 0, 160, 160, 320, 320, 480, 480, 4));
        send_curve(curve_of(-1, -1, 0, 0, 1, 1, -1, -1, 5));
        send_curve(curve_of(8, -8, -8, 8, 8, -8, -8, 8, 63));
        send_curve(curve_of(-20000, 15000, 30000, 30000, -30000, -30000, 20000, -15000,
                            33));
        send_curve(curve_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_curve(curve_of(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767,
                            1));
        drain_points();

        for (int i = 0; i < RANDOM_CURVES; i++) begin
            if (i == RANDOM_CURVES / 2) drain_points();
            send_curve(random_curve());
            rest_sender((i >= 40 && i < 80) ? 0 : pick_gap());
        end

        drain_points();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d curves: %0d with no points, %0d single-point, %0d capped.",
                 board.curves_noted, board.empty_curves, board.single_curves,
                 board.capped_curves);
        $display("Checked %0d curve points field by field.", board.points_checked);
        if (board.fail_count == 0 && board.expected_points.size() == 0) begin
            $display("** cubic_bezier_point_generator_top: PASSED **");
        end else begin
            $display("** cubic_bezier_point_generator_top: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/cbpg_pkg.sv
src/cbpg_div.sv
src/cubic_bezier_point_generator_top.sv
bench/cubic_bezier_point_generator_top_test.sv
